// ===== hw/rtl/running_time_statistics_macros.svh =====
// assertion helpers for the running time statistics block
`ifndef RUNNING_TIME_STATISTICS_MACROS_SVH
`define RUNNING_TIME_STATISTICS_MACROS_SVH

// same-cycle implication, checked outside reset
`define RTS_ASSERT_NOW(label, ck, rstn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("running_time_statistics: check failed");

// next-cycle implication, checked outside reset
`define RTS_ASSERT_NEXT(label, ck, rstn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("running_time_statistics: check failed");

`endif

// ===== hw/rtl/rts_pkg.sv =====
package rts_pkg;

  // default parameter values
  localparam int TIME_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // fixed field widths
  localparam int OUT_TIME_W  = 32;
  localparam int OUT_COUNT_W = 32;
  localparam int TOTAL_W     = 64;
  localparam int MEAN_W      = 48;
  localparam int VAR_W       = 63;

  // serial arithmetic unit sizes
  localparam int ACC_W    = 96;
  localparam int MPLIER_W = 48;
  localparam int STEP_W   = $clog2(ACC_W + 1);

  typedef struct packed {
    logic                  restart;
    logic [OUT_TIME_W-1:0] wall_time;
    logic [OUT_TIME_W-1:0] cpu_time;
  } in_t;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] sample_count;
    logic [TOTAL_W-1:0]     wall_total;
    logic [OUT_TIME_W-1:0]  wall_min;
    logic [OUT_TIME_W-1:0]  wall_max;
    logic [MEAN_W-1:0]      wall_mean;
    logic [VAR_W-1:0]       wall_variance;
    logic [TOTAL_W-1:0]     cpu_total;
    logic [OUT_TIME_W-1:0]  cpu_min;
    logic [OUT_TIME_W-1:0]  cpu_max;
    logic [MEAN_W-1:0]      cpu_mean;
    logic [VAR_W-1:0]       cpu_variance;
    logic                   saturated;
  } out_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } rts_op_t;

  typedef struct packed {
    logic              go;
    rts_op_t           op;
    logic [STEP_W-1:0] steps;
  } ser_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ser_stat_t;

  typedef struct packed {
    logic start;
    logic clear;
  } ch_ctrl_t;

  typedef struct packed {
    logic busy;
    logic sat;
  } ch_stat_t;

  typedef enum logic [2:0] {
    CH_IDLE     = 3'd0,
    CH_MEAN_MUL = 3'd1,
    CH_MEAN_DIV = 3'd2,
    CH_DEV      = 3'd3,
    CH_DEV_MUL  = 3'd4,
    CH_VAR_MUL  = 3'd5,
    CH_VAR_DIV  = 3'd6
  } ch_state_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_RUN    = 2'd1,
    ST_RESULT = 2'd2
  } top_state_t;

endpackage

// ===== hw/rtl/running_time_statistics.sv =====
// Running mean, population variance, minimum, maximum and saturating total of
// wall and CPU times, plus a shared sample count; each beat in gives one beat
// out with the statistics after the update, and a restart beat clears them.
// Both channels run side by side, each on its own bit-serial shift-add
// multiplier and restoring divider, one bit per cycle. A sample's result is
// registered after the three multiplies and two 96-bit divides in that unit
// (mean product and divide, deviation product, variance product and divide),
// and the next beat is taken only once that result is loaded into the output
// register, so samples never overlap. A restart's result is loaded from the
// result state, and the next beat is taken once it is in. The result sits in
// an output register, so the next beat is taken while an earlier result
// still waits; a finished item then holds the input until that register
// drains. Means are Q.FRAC_BITS and truncated; count, totals and variances
// saturate and set the sticky flag.
`include "running_time_statistics_macros.svh"

module running_time_statistics #(
  parameter int TIME_BITS  = rts_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = rts_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = rts_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rts_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rts_pkg::out_t out_data
);
  import rts_pkg::*;

  top_state_t            state_r, state_nxt;
  logic [COUNT_BITS-1:0] count_r;
  logic                  cnt_sat_r;
  logic                  out_valid_r;
  out_t                  out_data_r;

  logic     in_fire;
  logic     load_out;
  ch_ctrl_t ch_ctrl;
  ch_stat_t w_stat, c_stat;

  logic [TOTAL_W-1:0]   w_total, c_total;
  logic [TIME_BITS-1:0] w_low, w_high, c_low, c_high;
  logic [MEAN_W-1:0]    w_mean, c_mean;
  logic [VAR_W-1:0]     w_var, c_var;

  assign in_fire = in_valid && in_ready;
  assign ch_ctrl = '{start: in_fire && !in_data.restart,
                     clear: in_fire && in_data.restart};

  rts_chan #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_wall (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ch_ctrl),
    .x        (in_data.wall_time[TIME_BITS-1:0]),
    .n        (count_r),
    .stat     (w_stat),
    .total    (w_total),
    .low      (w_low),
    .high     (w_high),
    .mean     (w_mean),
    .variance (w_var)
  );

  rts_chan #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cpu (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ch_ctrl),
    .x        (in_data.cpu_time[TIME_BITS-1:0]),
    .n        (count_r),
    .stat     (c_stat),
    .total    (c_total),
    .low      (c_low),
    .high     (c_high),
    .mean     (c_mean),
    .variance (c_var)
  );

  // item sequencing
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = in_data.restart ? ST_RESULT : ST_RUN;
      end
      ST_RUN: begin
        if (!w_stat.busy && !c_stat.busy) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // shared sample count
  always_ff @(posedge clk) begin
    if (!rst_n || ch_ctrl.clear) begin
      count_r   <= '0;
      cnt_sat_r <= 1'b0;
    end else if (ch_ctrl.start) begin
      if (&count_r) begin
        cnt_sat_r <= 1'b1;
      end else begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.sample_count  <= OUT_COUNT_W'(count_r);
      out_data_r.wall_total    <= w_total;
      out_data_r.wall_min      <= OUT_TIME_W'(w_low);
      out_data_r.wall_max      <= OUT_TIME_W'(w_high);
      out_data_r.wall_mean     <= w_mean;
      out_data_r.wall_variance <= w_var;
      out_data_r.cpu_total     <= c_total;
      out_data_r.cpu_min       <= OUT_TIME_W'(c_low);
      out_data_r.cpu_max       <= OUT_TIME_W'(c_high);
      out_data_r.cpu_mean      <= c_mean;
      out_data_r.cpu_variance  <= c_var;
      out_data_r.saturated     <= cnt_sat_r | w_stat.sat | c_stat.sat;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `RTS_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_fire, !in_ready)
  `RTS_ASSERT_NEXT(a_restart_clears, clk, rst_n, ch_ctrl.clear, count_r == '0 && !cnt_sat_r)
  `RTS_ASSERT_NEXT(a_sample_counts, clk, rst_n, ch_ctrl.start, count_r != '0)
  `RTS_ASSERT_NOW(a_channels_lockstep, clk, rst_n, state_r == ST_RUN, w_stat.busy == c_stat.busy)

endmodule

// ===== hw/rtl/rts_serial.sv =====
module rts_serial #(
  parameter int COUNT_BITS = rts_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rts_pkg::ser_ctrl_t         ctrl,
  input  logic [rts_pkg::ACC_W-1:0]    acc_init,
  input  logic [rts_pkg::VAR_W-1:0]    mcand,
  input  logic [rts_pkg::MPLIER_W-1:0] mplier,
  input  logic [COUNT_BITS:0]        divisor,
  output rts_pkg::ser_stat_t         stat,
  output logic [rts_pkg::ACC_W-1:0]    acc
);
  import rts_pkg::*;

  logic [ACC_W-1:0]    acc_r;
  logic [VAR_W-1:0]    mcand_r;
  logic [MPLIER_W-1:0] mplier_r;
  logic [COUNT_BITS:0] div_r;
  logic [COUNT_BITS:0] rem_r;
  logic [STEP_W-1:0]   cnt_r;
  rts_op_t             op_r;
  logic                busy_r;
  logic                done_r;

  logic [ACC_W-1:0]      prod_nxt;
  logic [COUNT_BITS+1:0] rem_sh;
  logic [COUNT_BITS+1:0] rem_dif;
  logic                  rem_ge;
  logic [COUNT_BITS:0]   rem_nxt;
  logic [ACC_W-1:0]      quo_nxt;

  // one multiplier bit per cycle, msb first: double and add
  assign prod_nxt = {acc_r[ACC_W-2:0], 1'b0} +
                    (mplier_r[MPLIER_W-1] ? ACC_W'(mcand_r) : '0);

  // one quotient bit per cycle, restoring; quotient fills acc from the right
  assign rem_sh  = {rem_r, acc_r[ACC_W-1]};
  assign rem_dif = rem_sh - {1'b0, div_r};
  assign rem_ge  = rem_sh >= {1'b0, div_r};
  assign rem_nxt = rem_ge ? rem_dif[COUNT_BITS:0] : rem_sh[COUNT_BITS:0];
  assign quo_nxt = {acc_r[ACC_W-2:0], rem_ge};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.go) begin
        busy_r <= 1'b1;
        cnt_r  <= ctrl.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      op_r     <= ctrl.op;
      acc_r    <= (ctrl.op == OP_MUL) ? '0 : acc_init;
      mcand_r  <= mcand;
      mplier_r <= mplier;
      div_r    <= divisor;
      rem_r    <= '0;
    end else if (busy_r) begin
      unique case (op_r)
        OP_MUL: begin
          acc_r    <= prod_nxt;
          mplier_r <= {mplier_r[MPLIER_W-2:0], 1'b0};
        end
        OP_DIV: begin
          acc_r <= quo_nxt;
          rem_r <= rem_nxt;
        end
        default: ;
      endcase
    end
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign acc  = acc_r;

endmodule

// ===== hw/rtl/rts_chan.sv =====
module rts_chan #(
  parameter int TIME_BITS  = rts_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = rts_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = rts_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rts_pkg::ch_ctrl_t           ctrl,
  input  logic [TIME_BITS-1:0]        x,
  input  logic [COUNT_BITS-1:0]       n,
  output rts_pkg::ch_stat_t           stat,
  output logic [rts_pkg::TOTAL_W-1:0] total,
  output logic [TIME_BITS-1:0]        low,
  output logic [TIME_BITS-1:0]        high,
  output logic [rts_pkg::MEAN_W-1:0]  mean,
  output logic [rts_pkg::VAR_W-1:0]   variance
);
  import rts_pkg::*;

  ch_state_t            state_r, state_nxt;
  logic [TOTAL_W-1:0]   sum_r;
  logic [TIME_BITS-1:0] low_r, high_r;
  logic [MEAN_W-1:0]    avg_r, nw_r, xq_r;
  logic [VAR_W-1:0]     var_r;
  logic                 sat_r;
  logic [COUNT_BITS-1:0] n_r;
  logic [TOTAL_W-1:0]   t_r;
  logic                 neg_diff_r;

  ser_ctrl_t           ser_ctrl;
  ser_stat_t           ser_stat;
  logic [ACC_W-1:0]    ser_acc;
  logic [ACC_W-1:0]    acc_init;
  logic [VAR_W-1:0]    mcand;
  logic [MPLIER_W-1:0] mplier;
  logic [COUNT_BITS:0] divisor;

  logic [TOTAL_W:0]  sum_ext;
  logic [MEAN_W-1:0] xq_in;
  logic              neg1, neg2;
  logic [MEAN_W-1:0] m1, m2;
  logic [ACC_W-1:0]  t_ext, var_num;
  logic              quo_hi;

  rts_serial #(.COUNT_BITS(COUNT_BITS)) u_serial (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ser_ctrl),
    .acc_init (acc_init),
    .mcand    (mcand),
    .mplier   (mplier),
    .divisor  (divisor),
    .stat     (ser_stat),
    .acc      (ser_acc)
  );

  // sample scaling and saturating total
  assign xq_in   = MEAN_W'(x) << FRAC_BITS;
  assign sum_ext = {1'b0, sum_r} + (TOTAL_W + 1)'(x);
  assign divisor = {1'b0, n_r} + 1'b1;

  // deviations from old and new mean
  assign neg1 = xq_r < avg_r;
  assign neg2 = xq_r < nw_r;
  assign m1   = neg1 ? avg_r - xq_r : xq_r - avg_r;
  assign m2   = neg2 ? nw_r - xq_r : xq_r - nw_r;

  // variance numerator: var*n plus the signed deviation product, floored at zero
  assign t_ext = ACC_W'(t_r);
  always_comb begin
    if (neg_diff_r) begin
      var_num = (ser_acc < t_ext) ? '0 : ser_acc - t_ext;
    end else begin
      var_num = ser_acc + t_ext;
    end
  end
  assign quo_hi = |ser_acc[ACC_W-1:VAR_W];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ser_ctrl  = '{go: 1'b0, op: OP_MUL, steps: '0};
    acc_init  = '0;
    mcand     = '0;
    mplier    = '0;
    unique case (state_r)
      CH_IDLE: begin
        if (ctrl.start) begin
          ser_ctrl  = '{go: 1'b1, op: OP_MUL, steps: STEP_W'(COUNT_BITS)};
          mcand     = VAR_W'(avg_r);
          mplier    = {n, {(MPLIER_W-COUNT_BITS){1'b0}}};
          state_nxt = CH_MEAN_MUL;
        end
      end
      CH_MEAN_MUL: begin
        if (ser_stat.done) begin
          ser_ctrl  = '{go: 1'b1, op: OP_DIV, steps: STEP_W'(ACC_W)};
          acc_init  = ser_acc + ACC_W'(xq_r);
          state_nxt = CH_MEAN_DIV;
        end
      end
      CH_MEAN_DIV: begin
        if (ser_stat.done) begin
          state_nxt = CH_DEV;
        end
      end
      CH_DEV: begin
        ser_ctrl  = '{go: 1'b1, op: OP_MUL, steps: STEP_W'(MPLIER_W)};
        mcand     = VAR_W'(m1);
        mplier    = m2;
        state_nxt = CH_DEV_MUL;
      end
      CH_DEV_MUL: begin
        if (ser_stat.done) begin
          ser_ctrl  = '{go: 1'b1, op: OP_MUL, steps: STEP_W'(COUNT_BITS)};
          mcand     = var_r;
          mplier    = {n_r, {(MPLIER_W-COUNT_BITS){1'b0}}};
          state_nxt = CH_VAR_MUL;
        end
      end
      CH_VAR_MUL: begin
        if (ser_stat.done) begin
          ser_ctrl  = '{go: 1'b1, op: OP_DIV, steps: STEP_W'(ACC_W)};
          acc_init  = var_num;
          state_nxt = CH_VAR_DIV;
        end
      end
      CH_VAR_DIV: begin
        if (ser_stat.done) begin
          state_nxt = CH_IDLE;
        end
      end
      default: state_nxt = CH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CH_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // running statistics
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      sum_r  <= '0;
      low_r  <= '1;
      high_r <= '0;
      avg_r  <= '0;
      var_r  <= '0;
      sat_r  <= 1'b0;
    end else begin
      if (state_r == CH_IDLE && ctrl.start) begin
        if (sum_ext[TOTAL_W]) begin
          sum_r <= '1;
          sat_r <= 1'b1;
        end else begin
          sum_r <= sum_ext[TOTAL_W-1:0];
        end
        if (x < low_r) low_r <= x;
        if (x > high_r) high_r <= x;
      end
      if (state_r == CH_VAR_DIV && ser_stat.done) begin
        avg_r <= nw_r;
        if (quo_hi) begin
          var_r <= '1;
          sat_r <= 1'b1;
        end else begin
          var_r <= ser_acc[VAR_W-1:0];
        end
      end
    end
  end

  // per-item working values
  always_ff @(posedge clk) begin
    if (state_r == CH_IDLE && ctrl.start) begin
      n_r  <= n;
      xq_r <= xq_in;
    end
    if (state_r == CH_MEAN_DIV && ser_stat.done) begin
      nw_r <= ser_acc[MEAN_W-1:0];
    end
    if (state_r == CH_DEV) begin
      neg_diff_r <= neg1 ^ neg2;
    end
    if (state_r == CH_DEV_MUL && ser_stat.done) begin
      t_r <= ser_acc[2*FRAC_BITS +: TOTAL_W];
    end
  end

  assign stat     = '{busy: state_r != CH_IDLE, sat: sat_r};
  assign total    = sum_r;
  assign low      = low_r;
  assign high     = high_r;
  assign mean     = avg_r;
  assign variance = var_r;

endmodule
